// File: sv/rgbhsl_pkg.sv
`timescale 1ns / 1ps

package rgbhsl_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int HUE_BITS     = 16;
    localparam int SAT_BITS     = 16;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

endpackage

// File: sv/rgbhsl_div.sv
`timescale 1ns / 1ps

module rgbhsl_div #(
    parameter int DW = 11,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic [QW-1:0] i_en,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_div,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_div [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar j = 0; j < QW; j++) begin : g_step
        logic [DW-1:0] w_prem;
        logic [DW-1:0] w_pdiv;
        logic [QW-1:0] w_plow;
        logic [QW-1:0] w_pquo;
        logic [DW:0]   w_try;
        logic [DW:0]   w_sub;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_low;
        logic [QW-1:0] n_quo;

        if (j == 0) begin : g_first
            assign w_prem = i_rem;
            assign w_pdiv = i_div;
            assign w_plow = i_low;
            assign w_pquo = '0;
        end else begin : g_next
            assign w_prem = r_rem[j-1];
            assign w_pdiv = r_div[j-1];
            assign w_plow = r_low[j-1];
            assign w_pquo = r_quo[j-1];
        end

        always_comb begin
            w_try = {w_prem, w_plow[QW-1]};
            w_sub = w_try - {1'b0, w_pdiv};
            n_low = {w_plow[QW-2:0], 1'b0};
            if (w_try >= {1'b0, w_pdiv}) begin
                n_rem = w_sub[DW-1:0];
                n_quo = {w_pquo[QW-2:0], 1'b1};
            end else begin
                n_rem = w_try[DW-1:0];
                n_quo = {w_pquo[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem;
                r_div[j] <= w_pdiv;
                r_low[j] <= n_low;
                r_quo[j] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// File: sv/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps

// RGB to HSL pixel converter. Takes one pixel per clock while the output side takes words and
// returns hue (2^HUE_BITS is one full turn), saturation (65535 is fully saturated) and
// lightness (max + min channel). Every word passes through three stages of extremum, sector
// and offset logic followed by a restoring divider that resolves one quotient bit per stage.
// A new word is accepted every cycle while the output side takes words; empty stages close
// up under a stall. A grey pixel gives hue 0, and black or white gives saturation 0.

module rgb_to_hsl_converter #(
    parameter int CHANNEL_BITS = rgbhsl_pkg::CHANNEL_BITS,
    parameter int HUE_BITS     = rgbhsl_pkg::HUE_BITS,
    localparam int IN_W  = ((3 * CHANNEL_BITS) + 7) / 8 * 8,
    localparam int OUT_W = ((HUE_BITS + rgbhsl_pkg::SAT_BITS + CHANNEL_BITS + 1) + 7) / 8 * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // red, green, blue
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // hue, saturation, lightness
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int CB   = CHANNEL_BITS;
    localparam int SB   = rgbhsl_pkg::SAT_BITS;
    localparam int QW   = (HUE_BITS > SB) ? HUE_BITS : SB;
    localparam int DWH  = CB + 3;
    localparam int DWS  = CB;
    localparam int NS   = 3 + QW;
    localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;
    logic [NS-1:0] w_vin;

    for (genvar k = 0; k < NS; k++) begin : g_en
        assign w_en[k] = m_axis_tready || !(&r_vld[NS-1:k]);
        if (k == 0) begin : g_v0
            assign w_vin[k] = s_axis_tvalid;
        end else begin : g_vk
            assign w_vin[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NS-1];

    // Stage 1: extremes, sector, channel difference
    logic [CB-1:0] w_r, w_g, w_b;
    logic [CB-1:0] n1_mx, n1_mn;
    logic [CB:0]   n1_dif;
    rgbhsl_pkg::t_sector n1_sec;
    logic [CB-1:0] r1_mx, r1_mn;
    logic [CB:0]   r1_dif;
    rgbhsl_pkg::t_sector r1_sec;

    assign w_r = s_axis_tdata[CB-1:0];
    assign w_g = s_axis_tdata[2*CB-1:CB];
    assign w_b = s_axis_tdata[3*CB-1:2*CB];

    always_comb begin
        n1_mx = w_r;
        n1_mn = w_r;
        if (w_g > n1_mx) n1_mx = w_g;
        if (w_b > n1_mx) n1_mx = w_b;
        if (w_g < n1_mn) n1_mn = w_g;
        if (w_b < n1_mn) n1_mn = w_b;
        if (w_r >= w_g && w_r >= w_b) begin
            n1_sec = rgbhsl_pkg::SEC_RED;
            n1_dif = {1'b0, w_g} - {1'b0, w_b};
        end else if (w_g >= w_b) begin
            n1_sec = rgbhsl_pkg::SEC_GREEN;
            n1_dif = {1'b0, w_b} - {1'b0, w_r};
        end else begin
            n1_sec = rgbhsl_pkg::SEC_BLUE;
            n1_dif = {1'b0, w_r} - {1'b0, w_g};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mx  <= n1_mx;
            r1_mn  <= n1_mn;
            r1_dif <= n1_dif;
            r1_sec <= n1_sec;
        end
    end

    // Stage 2: chroma, sum, raw sector offset
    logic [CB-1:0] n2_c;
    logic [CB:0]   n2_sum;
    logic [CB+3:0] n2_base;
    logic [CB+3:0] n2_nraw;
    logic [CB-1:0] r2_c;
    logic [CB:0]   r2_sum;
    logic [CB+3:0] r2_nraw;

    always_comb begin
        n2_c   = r1_mx - r1_mn;
        n2_sum = {1'b0, r1_mx} + {1'b0, r1_mn};
        case (r1_sec)
            rgbhsl_pkg::SEC_GREEN: n2_base = (CB+4)'({n2_c, 1'b0});
            rgbhsl_pkg::SEC_BLUE:  n2_base = (CB+4)'({n2_c, 2'b00});
            default:               n2_base = '0;
        endcase
        n2_nraw = n2_base + {{3{r1_dif[CB]}}, r1_dif};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_c    <= n2_c;
            r2_sum  <= n2_sum;
            r2_nraw <= n2_nraw;
        end
    end

    // Stage 3: wrap offset, divisors, saturation numerator
    logic [CB+3:0]  n3_c6;
    logic [CB+3:0]  n3_nw;
    logic [CB:0]    n3_oth;
    logic [CB:0]    n3_sd;
    logic [DWH-1:0] r3_n;
    logic [DWH-1:0] r3_d6;
    logic [DWS-1:0] r3_sd;
    logic [CB+15:0] r3_x;
    logic [CB:0]    r3_sum;
    logic           r3_hz;
    logic           r3_sz;

    always_comb begin
        n3_c6  = (CB+4)'({r2_c, 2'b00}) + (CB+4)'({r2_c, 1'b0});
        n3_nw  = r2_nraw[CB+3] ? (r2_nraw + n3_c6) : r2_nraw;
        n3_oth = TWO_FULL - r2_sum;
        n3_sd  = (r2_sum < n3_oth) ? r2_sum : n3_oth;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_n   <= n3_nw[DWH-1:0];
            r3_d6  <= n3_c6[DWH-1:0];
            r3_sd  <= n3_sd[DWS-1:0];
            r3_x   <= {r2_c, {SB{1'b0}}} - (CB+16)'(r2_c);
            r3_sum <= r2_sum;
            r3_hz  <= (r2_c == '0);
            r3_sz  <= (n3_sd == '0);
        end
    end

    // Divider stages
    logic [DWH+QW-1:0] w_hnum;
    logic [DWS+QW-1:0] w_snum;
    logic [QW-1:0]     w_hquo;
    logic [QW-1:0]     w_squo;

    assign w_hnum = (DWH+QW)'({r3_n, {HUE_BITS{1'b0}}});
    assign w_snum = (DWS+QW)'(r3_x);

    rgbhsl_div #(
        .DW (DWH),
        .QW (QW)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_en[NS-1:3]),
        .i_rem (w_hnum[DWH+QW-1:QW]),
        .i_low (w_hnum[QW-1:0]),
        .i_div (r3_d6),
        .o_quo (w_hquo)
    );

    rgbhsl_div #(
        .DW (DWS),
        .QW (QW)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_en[NS-1:3]),
        .i_rem (w_snum[DWS+QW-1:QW]),
        .i_low (w_snum[QW-1:0]),
        .i_div (r3_sd),
        .o_quo (w_squo)
    );

    logic [CB:0] r_lit [QW];
    logic        r_hz  [QW];
    logic        r_sz  [QW];

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QW; j++) begin
            if (w_en[3+j]) begin
                if (j == 0) begin
                    r_lit[j] <= r3_sum;
                    r_hz[j]  <= r3_hz;
                    r_sz[j]  <= r3_sz;
                end else begin
                    r_lit[j] <= r_lit[j-1];
                    r_hz[j]  <= r_hz[j-1];
                    r_sz[j]  <= r_sz[j-1];
                end
            end
        end
    end

    logic [HUE_BITS-1:0] w_hue;
    logic [SB-1:0]       w_sat;

    assign w_hue = r_hz[QW-1] ? '0 : w_hquo[HUE_BITS-1:0];
    assign w_sat = r_sz[QW-1] ? '0 : w_squo[SB-1:0];
    assign m_axis_tdata = OUT_W'({r_lit[QW-1], w_sat, w_hue});

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output stage is empty");

    a_black_white_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_sz[QW-1]) |-> r_hz[QW-1])
        else $error("zero saturation divisor with nonzero chroma");

    a_black_white_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_sz[QW-1]) |-> (r_lit[QW-1] == '0 || r_lit[QW-1] == TWO_FULL))
        else $error("zero saturation divisor with mid lightness");

    a_lit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_lit[QW-1] <= TWO_FULL))
        else $error("lightness out of range");

endmodule

// File: bench/rgb_to_hsl_checker.sv
`timescale 1ns / 1ps

module rgb_to_hsl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // red, green, blue
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // hue, saturation, lightness
    input  logic [47:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [8:0]  light;
    } t_hsl;

    t_hsl hsl_q[$];
    int   fail_cnt = 0;
    int   pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic t_hsl pixel_to_hsl(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        t_hsl                res;
        rgbhsl_pkg::t_sector sec;
        int                  mx;
        int                  mn;
        int                  chroma;
        int                  sum;
        int                  n;
        int                  div;
        int                  sat;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        chroma = mx - mn;
        sum = mx + mn;
        res.hue = '0;
        res.sat = '0;
        if (chroma != 0) begin
            if (r >= g && r >= b) sec = rgbhsl_pkg::SEC_RED;
            else if (g >= b) sec = rgbhsl_pkg::SEC_GREEN;
            else sec = rgbhsl_pkg::SEC_BLUE;
            case (sec)
                rgbhsl_pkg::SEC_RED:   n = int'(g) - int'(b);
                rgbhsl_pkg::SEC_GREEN: n = 2 * chroma + int'(b) - int'(r);
                default:               n = 4 * chroma + int'(r) - int'(g);
            endcase
            if (n < 0) n = n + 6 * chroma;
            res.hue = 16'((n * 65536) / (6 * chroma));
        end
        div = (sum < 510 - sum) ? sum : 510 - sum;
        if (div != 0) begin
            sat = (chroma * 65535) / div;
            res.sat = (sat > 65535) ? 16'hFFFF : 16'(sat);
        end
        res.light = 9'(sum);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
        fail_cnt = fail_cnt + 1;
    endtask

    always @(posedge i_clk) begin
        t_hsl want;
        if (!i_rst_n) begin
            hsl_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (hsl_q.size() == 0) begin
                    report_mismatch("unexpected word", int'(i_m_tdata[15:0]), -1);
                end else begin
                    want = hsl_q.pop_front();
                    if (i_m_tdata[15:0] !== want.hue)
                        report_mismatch("hue", int'(i_m_tdata[15:0]), int'(want.hue));
                    if (i_m_tdata[31:16] !== want.sat)
                        report_mismatch("saturation", int'(i_m_tdata[31:16]), int'(want.sat));
                    if (i_m_tdata[40:32] !== want.light)
                        report_mismatch("lightness", int'(i_m_tdata[40:32]),
                                        int'(want.light));
                end
            end
            if (i_s_tvalid && i_s_tready)
                hsl_q.push_back(pixel_to_hsl(i_s_tdata[7:0], i_s_tdata[15:8],
                                             i_s_tdata[23:16]));
        end
        pending_cnt = hsl_q.size();
    end

endmodule

// File: bench/rgb_to_hsl_converter_tb.sv
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;

    localparam int RANDOM_PIXELS  = 1750;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // red, green, blue
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // hue, saturation, lightness
    logic [47:0] m_tdata;
    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    int          ready_hold = 0;
    int          idle_cycles = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    rgb_to_hsl_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    rgb_to_hsl_checker hsl_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (calm || roll < 60) return 0;
        if (roll < 90) return int'($urandom_range(1, 3));
        if (roll < 98) return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 40));
    endfunction

    // stall the output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b, g, r};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_random_pixel();
        int          roll;
        logic [7:0]  base;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        roll = int'($urandom_range(0, 99));
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        base = 8'($urandom_range(2, 253));
        if (roll < 50) begin
        end else if (roll < 65) begin
            r = 8'(base + $urandom_range(0, 4) - 2);
            g = 8'(base + $urandom_range(0, 4) - 2);
            b = 8'(base + $urandom_range(0, 4) - 2);
        end else if (roll < 75) begin
            case ($urandom_range(0, 2))
                0:       g = r;
                1:       b = g;
                default: b = r;
            endcase
        end else if (roll < 85) begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
        end else if (roll < 95) begin
            r = 8'($urandom_range(252, 255));
            g = 8'($urandom_range(252, 255));
            b = 8'($urandom_range(252, 255));
        end else begin
            g = r;
            b = r;
        end
        send_pixel(r, g, b);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd200, 8'd10,  8'd50);
        send_pixel(8'd200, 8'd50,  8'd10);
        send_pixel(8'd10,  8'd200, 8'd50);
        send_pixel(8'd50,  8'd200, 8'd10);
        send_pixel(8'd10,  8'd50,  8'd200);
        send_pixel(8'd50,  8'd10,  8'd200);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd254);
        send_pixel(8'd254, 8'd255, 8'd255);
        send_pixel(8'd127, 8'd128, 8'd128);
        send_pixel(8'd128, 8'd127, 8'd127);
        send_pixel(8'd0,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd255, 8'd254);
        send_pixel(8'd85,  8'd170, 8'd255);
        send_pixel(8'd170, 8'd85,  8'd0);

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 150 == 0) calm = ($urandom_range(0, 3) == 0);
            send_random_pixel();
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/rgbhsl_pkg.sv
sv/rgbhsl_div.sv
sv/rgb_to_hsl_converter.sv
bench/rgb_to_hsl_checker.sv
bench/rgb_to_hsl_converter_tb.sv
